### rtl/lmet_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the label mask extent tracker.
// Operation codes and the packed entry layouts of the column and area stores.
package lmet_pkg;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_PIXEL    = 2'd1;
  localparam logic [1:0] OP_READ_COL = 2'd2;
  localparam logic [1:0] OP_READ_BOX = 2'd3;

  // column extent: bottom is exclusive, so it needs one extra bit
  typedef struct packed {
    logic        valid;
    logic [9:0]  top;
    logic [10:0] bottom_excl;
  } col_entry_t;

  // area box; its seen flag lives in flip-flops next to the memory
  typedef struct packed {
    logic [9:0] left;
    logic [9:0] top;
    logic [9:0] right;
    logic [9:0] bottom;
  } box_entry_t;

endpackage

### rtl/lmet_col_store.sv
`timescale 1ns / 1ps
// Column extent memory: synchronous read, write forwarding and a
// clearing sweep after reset or on request. Uses lmet_pkg.
module lmet_col_store
  import lmet_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  output logic                     busy,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output col_entry_t               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  col_entry_t               wr_data
);

  localparam int AW = $clog2(DEPTH);

  col_entry_t mem [DEPTH];
  col_entry_t mem_q;
  logic [AW-1:0] rd_addr_q;
  logic [AW-1:0] cnt;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  col_entry_t    fwd_data;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  col_entry_t    mem_wdata;

  assign mem_we    = busy || wr_en;
  assign mem_waddr = busy ? cnt : wr_addr;
  assign mem_wdata = busy ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // last write wins over a read issued at the same edge
  always_ff @(posedge clk) begin
    if (rst || clear || busy) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !busy) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  assign rd_data = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data : mem_q;

endmodule

### rtl/lmet_box_store.sv
`timescale 1ns / 1ps
// Area box memory with per-entry seen flags in flip-flops and write
// forwarding on the registered read path. Uses lmet_pkg.
module lmet_box_store
  import lmet_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_valid,
  output box_entry_t               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  box_entry_t               wr_data
);

  localparam int AW = $clog2(DEPTH);

  box_entry_t mem [DEPTH];
  box_entry_t mem_q;
  logic [AW-1:0] rd_addr_q;
  logic [DEPTH-1:0] seen;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  box_entry_t    fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      seen <= '0;
    end else if (wr_en) begin
      seen[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  assign rd_valid = seen[rd_addr_q];
  assign rd_data  = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data : mem_q;

endmodule

### rtl/label_mask_extent_tracker.sv
`timescale 1ns / 1ps
// Label mask extent tracker: per-column row extents and per-label boxes.
// Uses lmet_pkg, lmet_col_store and lmet_box_store.
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation, pix_x, pix_y, label
//   and area_index. Clear and pixel operations give no result; column and
//   area reads give one result on the output channel (out_valid/out_ready).
//   Throughput is one item per cycle while input is not held off: an item
//   reads the column and area memories at its transfer, and the next
//   cycle modifies and writes back, with the last write forwarded to a
//   read of the same entry. A read result is loaded into the output
//   register from the modify stage. While the receiver stalls, one read
//   waits in the modify stage and further input is held off; pixels keep
//   flowing while the output register is full and no read is waiting.
//   After reset the column memory is swept empty, one entry per cycle, with
//   in_ready low. A clear blocks input from its transfer until the same
//   sweep has ended; area flags and the any-area flag clear at once.
module label_mask_extent_tracker
  import lmet_pkg::*;
#(
  parameter int NUM_AREAS   = 16,
  parameter int MASK_WIDTH  = 1024,
  parameter int MASK_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [9:0]  pix_x,
  input  logic [9:0]  pix_y,
  input  logic [7:0]  label,
  input  logic [3:0]  area_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [9:0]  col_top,
  output logic [10:0] col_bottom_excl,
  output logic [9:0]  box_left,
  output logic [9:0]  box_top,
  output logic [9:0]  box_right,
  output logic [9:0]  box_bottom,
  output logic        any_area
);

  localparam int CW = $clog2(MASK_WIDTH);
  localparam int AW = $clog2(NUM_AREAS);

  logic accept;
  logic x_ok, y_ok, lab_ok, ai_ok;
  logic in_hit, in_rd_ok;

  logic          s1_valid;
  logic [1:0]    s1_op;
  logic [9:0]    s1_x;
  logic [9:0]    s1_y;
  logic          s1_hit;
  logic          s1_rd_ok;
  logic [CW-1:0] s1_col_idx;
  logic [AW-1:0] s1_box_idx;
  logic          s1_is_read;
  logic          s1_advance;
  logic          s1_clear;

  logic       col_busy;
  col_entry_t col_rd, col_new;
  logic       box_rd_valid;
  box_entry_t box_rd, box_new;
  logic       any_seen;

  logic [10:0] y_inc;
  logic        res_found;
  logic [9:0]  res_col_top;
  logic [10:0] res_col_bottom;
  box_entry_t  res_box;

  assign x_ok   = 32'(pix_x) < MASK_WIDTH;
  assign y_ok   = 32'(pix_y) < MASK_HEIGHT;
  assign lab_ok = (label != 8'd0) && (32'(label) < NUM_AREAS);
  assign ai_ok  = 32'(area_index) < NUM_AREAS;

  assign in_hit   = (operation == OP_PIXEL) && x_ok && y_ok && lab_ok;
  assign in_rd_ok = (operation == OP_READ_COL) ? x_ok : ai_ok;

  assign s1_is_read = (s1_op == OP_READ_COL) || (s1_op == OP_READ_BOX);
  assign s1_clear   = s1_valid && (s1_op == OP_CLEAR);
  assign s1_advance = !s1_valid || !s1_is_read || !out_valid || out_ready;
  assign in_ready   = !col_busy && !s1_clear && s1_advance;
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= operation;
      s1_x       <= pix_x;
      s1_y       <= pix_y;
      s1_hit     <= in_hit;
      s1_rd_ok   <= in_rd_ok;
      s1_col_idx <= CW'(pix_x);
      s1_box_idx <= AW'(label);
    end
  end

  lmet_col_store #(
    .DEPTH (MASK_WIDTH)
  ) u_col_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (s1_clear),
    .busy    (col_busy),
    .rd_en   (accept),
    .rd_addr (CW'(pix_x)),
    .rd_data (col_rd),
    .wr_en   (s1_valid && s1_hit),
    .wr_addr (s1_col_idx),
    .wr_data (col_new)
  );

  lmet_box_store #(
    .DEPTH (NUM_AREAS)
  ) u_box_store (
    .clk      (clk),
    .rst      (rst),
    .clear    (s1_clear),
    .rd_en    (accept),
    .rd_addr  ((operation == OP_READ_BOX) ? AW'(area_index) : AW'(label)),
    .rd_valid (box_rd_valid),
    .rd_data  (box_rd),
    .wr_en    (s1_valid && s1_hit),
    .wr_addr  (s1_box_idx),
    .wr_data  (box_new)
  );

  // merge the pixel into the column extent and the area box
  assign y_inc = {1'b0, s1_y} + 11'd1;

  always_comb begin
    col_new.valid       = 1'b1;
    col_new.top         = (!col_rd.valid || s1_y < col_rd.top) ? s1_y : col_rd.top;
    col_new.bottom_excl = (!col_rd.valid || y_inc > col_rd.bottom_excl) ?
                          y_inc : col_rd.bottom_excl;

    box_new.left   = (!box_rd_valid || s1_x < box_rd.left)   ? s1_x : box_rd.left;
    box_new.right  = (!box_rd_valid || s1_x > box_rd.right)  ? s1_x : box_rd.right;
    box_new.top    = (!box_rd_valid || s1_y < box_rd.top)    ? s1_y : box_rd.top;
    box_new.bottom = (!box_rd_valid || s1_y > box_rd.bottom) ? s1_y : box_rd.bottom;
  end

  always_ff @(posedge clk) begin
    if (rst || s1_clear) begin
      any_seen <= 1'b0;
    end else if (s1_valid && s1_hit) begin
      any_seen <= 1'b1;
    end
  end

  // read result; fields of the other kind of read stay zero
  always_comb begin
    res_found      = 1'b0;
    res_col_top    = '0;
    res_col_bottom = '0;
    res_box        = '0;
    if (s1_op == OP_READ_COL) begin
      if (s1_rd_ok && col_rd.valid) begin
        res_found      = 1'b1;
        res_col_top    = col_rd.top;
        res_col_bottom = col_rd.bottom_excl;
      end
    end else if (s1_rd_ok && box_rd_valid) begin
      res_found = 1'b1;
      res_box   = box_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_is_read && s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_is_read && s1_advance) begin
      found           <= res_found;
      col_top         <= res_col_top;
      col_bottom_excl <= res_col_bottom;
      box_left        <= res_box.left;
      box_top         <= res_box.top;
      box_right       <= res_box.right;
      box_bottom      <= res_box.bottom;
      any_area        <= any_seen;
    end
  end

  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    s1_clear |=> (col_busy && !any_seen && !in_ready))
    else $error("clear did not start the column sweep");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_is_read))
    else $error("result produced without a read in the modify stage");

  a_col_extent_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found && col_bottom_excl != 11'd0) |->
      (col_bottom_excl > {1'b0, col_top}))
    else $error("column extent bottom not below top");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found && col_bottom_excl == 11'd0) |->
      (box_left <= box_right && box_top <= box_bottom))
    else $error("area box corners out of order");

endmodule
